// ===== rtl/core/json_string_literal_decoder_top_defines.svh =====
// Assertion macros for the JSON string decoder.
`ifndef JSON_STRING_LITERAL_DECODER_TOP_DEFINES_SVH
`define JSON_STRING_LITERAL_DECODER_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define JSLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsld: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define JSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsld: next-cycle check failed");

`endif

// ===== rtl/core/jsld_pkg.sv =====
// Shared types and constants for the JSON string decoder.
package jsld_pkg;

    localparam int COUNT_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] MAX_LENGTH_RST = 8'd32;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic [1:0]      status;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

endpackage

// ===== rtl/core/json_string_literal_decoder_top.sv =====
// JSON string literal decoder: top level with config register and checks.
// Throughput: one input byte per cycle while the run queue has room.
// Output: one transfer per decoded byte, so a 4-byte sequence gives 4 transfers.
// A taken byte's run is queued, then popped into the back end's run register for output.
// Run queue of QUEUE_DEPTH entries decouples input from output stalls.
// Reset (synchronous, active low): idle awaiting opening quote, queue empty, max_length 32.
`include "json_string_literal_decoder_top_defines.svh"

module json_string_literal_decoder_top import jsld_pkg::*; #(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    input  t_in        i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_out       o_data,
    input  logic       i_stall
);

    logic [7:0]   r_max_length;
    logic         w_fire;
    logic         w_push;
    logic         w_pop;
    t_run         w_run_in;
    t_run         w_run_out;
    t_queue_flags w_flags;

    assign o_stall = w_flags.full;
    assign w_fire  = i_valid && !w_flags.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    jsld_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_fire       (w_fire),
        .i_data       (i_data),
        .o_run        (w_run_in),
        .o_push       (w_push)
    );

    jsld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run_in),
        .i_pop   (w_pop),
        .o_run   (w_run_out),
        .o_flags (w_flags)
    );

    jsld_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_run   (w_run_out),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    `JSLD_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_flags.full)
    `JSLD_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, w_pop, !w_flags.empty)
    `JSLD_ASSERT_NEXT(a_pop_gives_valid, i_clk, i_rst_n, w_pop, o_valid)
    `JSLD_ASSERT_NOW(a_status_only_last, i_clk, i_rst_n, o_valid && (o_data.status != ST_BUSY), o_data.run_last)
    `JSLD_ASSERT_NOW(a_empty_run_has_status, i_clk, i_rst_n, o_valid && !o_data.byte_valid, o_data.run_last && (o_data.status != ST_BUSY))

endmodule

// ===== rtl/core/jsld_front.sv =====
// Front end: per-byte decode of escapes and UTF-8 into output runs.
module jsld_front import jsld_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_max_length,
    input  logic       i_fire,
    input  t_in        i_data,
    output t_run       o_run,
    output logic       o_push
);

    localparam int LW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
    localparam logic [LW-1:0] LIMIT = LW'((1 << COUNT_BITS) - 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef enum logic [3:0] {
        PH_IDLE, PH_TEXT, PH_ESC, PH_HEX_HI, PH_SLASH, PH_U, PH_HEX_LO, PH_CONT
    } t_phase;

    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] h;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h = {1'b0, 4'(c[3:0] + 4'd9)};
        end else begin
            h = 5'h10;
        end
        return h;
    endfunction

    function automatic logic [2:0] f_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp <= 21'h7f) begin
            n = 3'd1;
        end else if (cp <= 21'h7ff) begin
            n = 3'd2;
        end else if (cp <= 21'hffff) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [3:0][7:0] f_enc(input logic [20:0] cp);
        logic [3:0][7:0] b;
        b = '0;
        unique case (f_len(cp))
            3'd1: begin
                b[0] = cp[7:0];
            end
            3'd2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        return b;
    endfunction

    t_phase                r_phase, n_phase;
    logic [20:0]           r_cp, n_cp;
    logic [9:0]            r_hs, n_hs;
    logic [1:0]            r_dl, n_dl;
    logic [1:0]            r_cl, n_cl;
    logic [2:0]            r_sl, n_sl;
    logic [COUNT_BITS-1:0] r_be, n_be;

    logic [7:0]      w_c;
    logic [LW-1:0]   w_cap;
    logic [LW-1:0]   w_be_ext;
    logic [4:0]      w_hex;
    logic [15:0]     w_cp16;
    logic [20:0]     w_cont;
    logic [20:0]     w_enc_cp;
    logic            w_emit;
    logic            w_chk;
    logic [2:0]      w_len;
    logic [3:0][7:0] w_bytes;
    logic [2:0]      w_nb;
    logic [1:0]      w_st;
    logic [2:0]      w_lead_n;
    logic [4:0]      w_lead_bits;
    logic            w_lead_ok;
    logic [7:0]      w_esc;
    logic            w_esc_ok;

    assign w_c      = i_data.in_byte;
    assign w_cap    = (LW'(i_max_length) < LIMIT) ? LW'(i_max_length) : LIMIT;
    assign w_be_ext = LW'(r_be);
    assign w_hex    = f_hex(w_c);
    assign w_cp16   = {r_cp[11:0], w_hex[3:0]};
    assign w_cont   = {r_cp[14:0], w_c[5:0]};

    always_comb begin
        w_lead_ok   = 1'b1;
        w_lead_n    = 3'd2;
        w_lead_bits = {w_c[4:0]};
        if (w_c >= 8'hc2 && w_c <= 8'hdf) begin
            w_lead_n    = 3'd2;
            w_lead_bits = w_c[4:0];
        end else if (w_c >= 8'he0 && w_c <= 8'hef) begin
            w_lead_n    = 3'd3;
            w_lead_bits = {1'b0, w_c[3:0]};
        end else if (w_c >= 8'hf0 && w_c <= 8'hf4) begin
            w_lead_n    = 3'd4;
            w_lead_bits = {2'b00, w_c[2:0]};
        end else begin
            w_lead_ok = 1'b0;
        end
    end

    always_comb begin
        w_esc_ok = 1'b1;
        w_esc    = w_c;
        priority if (w_c == CH_QUOTE || w_c == CH_BSLASH || w_c == CH_SLASH) begin
            w_esc = w_c;
        end else if (w_c == CH_B) begin
            w_esc = 8'h08;
        end else if (w_c == CH_F) begin
            w_esc = 8'h0c;
        end else if (w_c == CH_N) begin
            w_esc = 8'h0a;
        end else if (w_c == CH_R) begin
            w_esc = 8'h0d;
        end else if (w_c == CH_T) begin
            w_esc = 8'h09;
        end else begin
            w_esc_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cp     = r_cp;
        n_hs     = r_hs;
        n_dl     = r_dl;
        n_cl     = r_cl;
        n_sl     = r_sl;
        w_st     = ST_BUSY;
        w_emit   = 1'b0;
        w_chk    = 1'b0;
        w_enc_cp = 21'(w_c);
        unique case (r_phase)
            PH_IDLE: begin
                if (w_c == CH_QUOTE) begin
                    n_phase = PH_TEXT;
                end else begin
                    w_st = ST_ERR;
                end
            end
            PH_TEXT: begin
                priority if (w_c == CH_QUOTE) begin
                    w_st = ST_DONE;
                end else if (w_c < 8'h20) begin
                    w_st = ST_ERR;
                end else if (w_c == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else if (w_c[7]) begin
                    if (!w_lead_ok || (w_be_ext + LW'(w_lead_n) > w_cap)) begin
                        w_st = ST_ERR;
                    end else begin
                        n_cp    = 21'(w_lead_bits);
                        n_sl    = w_lead_n;
                        n_cl    = 2'(w_lead_n - 3'd1);
                        n_phase = PH_CONT;
                    end
                end else begin
                    w_emit   = 1'b1;
                    w_chk    = 1'b1;
                    w_enc_cp = 21'(w_c);
                end
            end
            PH_ESC: begin
                if (w_c == CH_U) begin
                    n_phase = PH_HEX_HI;
                    n_dl    = 2'd3;
                    n_cp    = '0;
                end else if (!w_esc_ok) begin
                    w_st = ST_ERR;
                end else begin
                    w_emit   = 1'b1;
                    w_chk    = 1'b1;
                    w_enc_cp = 21'(w_esc);
                    n_phase  = PH_TEXT;
                end
            end
            PH_HEX_HI, PH_HEX_LO: begin
                if (w_hex[4]) begin
                    w_st = ST_ERR;
                end else begin
                    n_cp = 21'(w_cp16);
                    if (r_dl != 2'd0) begin
                        n_dl = r_dl - 2'd1;
                    end else if (r_phase == PH_HEX_HI) begin
                        priority if (w_cp16 >= 16'hd800 && w_cp16 <= 16'hdbff) begin
                            n_hs    = w_cp16[9:0];
                            n_phase = PH_SLASH;
                        end else if (w_cp16 >= 16'hdc00) begin
                            if (w_cp16 <= 16'hdfff) begin
                                w_st = ST_ERR;
                            end else begin
                                w_emit   = 1'b1;
                                w_chk    = 1'b1;
                                w_enc_cp = 21'(w_cp16);
                                n_phase  = PH_TEXT;
                            end
                        end else begin
                            w_emit   = 1'b1;
                            w_chk    = 1'b1;
                            w_enc_cp = 21'(w_cp16);
                            n_phase  = PH_TEXT;
                        end
                    end else begin
                        if (w_cp16 < 16'hdc00 || w_cp16 > 16'hdfff) begin
                            w_st = ST_ERR;
                        end else begin
                            w_emit   = 1'b1;
                            w_chk    = 1'b1;
                            w_enc_cp = 21'h10000 + {1'b0, r_hs, w_cp16[9:0]};
                            n_phase  = PH_TEXT;
                        end
                    end
                end
            end
            PH_SLASH: begin
                if (w_c == CH_BSLASH) begin
                    n_phase = PH_U;
                end else begin
                    w_st = ST_ERR;
                end
            end
            PH_U: begin
                if (w_c == CH_U) begin
                    n_phase = PH_HEX_LO;
                    n_dl    = 2'd3;
                    n_cp    = '0;
                end else begin
                    w_st = ST_ERR;
                end
            end
            PH_CONT: begin
                if (w_c[7:6] != 2'b10) begin
                    w_st = ST_ERR;
                end else begin
                    n_cp = w_cont;
                    if (r_cl > 2'd1) begin
                        n_cl = r_cl - 2'd1;
                    end else begin
                        n_cl = 2'd0;
                        if ((r_sl == 3'd2 && w_cont < 21'h80) ||
                            (r_sl == 3'd3 && w_cont < 21'h800) ||
                            (r_sl == 3'd4 && w_cont < 21'h10000) ||
                            (w_cont >= 21'hd800 && w_cont <= 21'hdfff) ||
                            (w_cont > 21'h10ffff)) begin
                            w_st = ST_ERR;
                        end else begin
                            w_emit   = 1'b1;
                            w_enc_cp = w_cont;
                            n_phase  = PH_TEXT;
                        end
                    end
                end
            end
            default: begin
                w_st = ST_ERR;
            end
        endcase

        w_len   = f_len(w_enc_cp);
        w_bytes = f_enc(w_enc_cp);
        w_nb    = 3'd0;
        if (w_emit) begin
            if ((w_enc_cp >= 21'h80 && w_enc_cp <= 21'h9f) ||
                (w_chk && (w_be_ext + LW'(w_len) > w_cap))) begin
                w_st = ST_ERR;
            end else begin
                w_nb = w_len;
            end
        end

        if (w_st == ST_BUSY && i_data.final_byte && n_phase != PH_IDLE) begin
            w_st = ST_ERR;
        end

        n_be = r_be + COUNT_BITS'(w_nb);

        if (w_st != ST_BUSY) begin
            n_phase = PH_IDLE;
            n_cp    = '0;
            n_hs    = '0;
            n_dl    = '0;
            n_cl    = '0;
            n_sl    = '0;
            n_be    = '0;
        end
    end

    assign o_run.bytes  = w_bytes;
    assign o_run.count  = w_nb;
    assign o_run.status = w_st;
    assign o_push       = i_fire && (w_nb != 3'd0 || w_st != ST_BUSY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cp    <= '0;
            r_hs    <= '0;
            r_dl    <= '0;
            r_cl    <= '0;
            r_sl    <= '0;
            r_be    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cp    <= n_cp;
            r_hs    <= n_hs;
            r_dl    <= n_dl;
            r_cl    <= n_cl;
            r_sl    <= n_sl;
            r_be    <= n_be;
        end
    end

endmodule

// ===== rtl/core/jsld_queue.sv =====
// Run queue between the decode front end and the output serialiser.
module jsld_queue import jsld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_run         i_run,
    input  logic         i_pop,
    output t_run         o_run,
    output t_queue_flags o_flags
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;

    assign o_run         = r_mem[r_head];
    assign o_flags.full  = (r_count == CW'(DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + PW'(1);
            end
            if (i_pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/jsld_back.sv =====
// Back end: serialise each run into one output transfer per byte, or one status-only transfer for a run with no bytes.
module jsld_back import jsld_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_queue_flags i_flags,
    input  t_run         i_run,
    output logic         o_pop,
    output logic         o_valid,
    output t_out         o_data,
    input  logic         i_stall
);

    logic       r_busy;
    t_run       r_run;
    logic [1:0] r_idx;

    logic w_fire;
    logic w_last;

    assign w_fire = r_busy && !i_stall;
    assign w_last = (r_run.count == 3'd0) || ({1'b0, r_idx} + 3'd1 == r_run.count);
    assign o_pop  = (!r_busy || (w_fire && w_last)) && !i_flags.empty;

    assign o_valid           = r_busy;
    assign o_data.out_byte   = (r_run.count == 3'd0) ? 8'd0 : r_run.bytes[r_idx];
    assign o_data.byte_valid = (r_run.count != 3'd0);
    assign o_data.status     = w_last ? r_run.status : ST_BUSY;
    assign o_data.run_last   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_fire && w_last) begin
            r_busy <= 1'b0;
        end else if (w_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_run;
        end
    end

endmodule
